// ===== rtl/core/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared sizes, request kinds and response status codes of the slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int BOARDS          = 16;
  localparam int SLOTS_PER_BOARD = 64;
  localparam int BOARD_STRIDE    = 64;

  localparam int BOARD_W  = (BOARDS > 1) ? $clog2(BOARDS) : 1;
  localparam int SLOT_W   = $clog2(BOARD_STRIDE);
  localparam int FILL_W   = $clog2(SLOTS_PER_BOARD + 1);
  localparam int HANDLE_W = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  localparam logic KIND_BORROW = 1'b0;
  localparam logic KIND_RETURN = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

endpackage

// ===== rtl/core/psa_if.sv =====
// ----------------------------------------------------------------------------
// psa_req_if / psa_rsp_if
// Valid/ready channels that carry allocator requests and their responses.
// ----------------------------------------------------------------------------
interface psa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [psa_pkg::HANDLE_W-1:0]  handle;

  modport source (output valid, kind, handle, input ready);
  modport sink   (input valid, kind, handle, output ready);
endinterface

interface psa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [psa_pkg::STATUS_W-1:0]  status;
  logic [psa_pkg::HANDLE_W-1:0]  granted;
  logic                          board_released;
  logic [psa_pkg::COUNT_W-1:0]   live_count;

  modport source (output valid, status, granted, board_released, live_count, input ready);
  modport sink   (input valid, status, granted, board_released, live_count, output ready);
endinterface

// ===== rtl/core/psa_ram.sv =====
// ----------------------------------------------------------------------------
// psa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module psa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pooled_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// pooled_slot_allocator
// Fixed-size slot allocator over a fixed set of boards of slots.
// ----------------------------------------------------------------------------
// A request on req either borrows a slot (kind 0) or returns the slot named
// by handle (kind 1). Every request yields exactly one response on rsp with
// a status, the granted handle, a board release flag and the live count.
// The block takes a request when it is idle; in that cycle it picks the
// board and reads that board's busy map from the map RAM. In the update
// state that follows, which waits on the registered read of the map RAM
// and on a free response register, it finds the slot, writes the map back
// and loads the response register. No new request is taken before that.
// The response register lets a new request be taken while the previous
// response still waits. If the receiver stalls and the register is still
// full, the update cycle waits until the response is taken.
// Reset clears all board state and the live count at once. The map RAM is
// not cleared; a board's map is treated as empty when the board is
// activated, and maps of inactive boards are never used.
// ----------------------------------------------------------------------------
module pooled_slot_allocator (
  input logic      clk,
  input logic      rst,
  psa_req_if.sink  req,
  psa_rsp_if.source rsp
);

  import psa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t                     state;
  logic                       board_active  [BOARDS];
  logic [FILL_W-1:0]          board_fill    [BOARDS];
  logic [BOARD_W-1:0]         board_recency [BOARDS];
  logic [COUNT_W-1:0]         pool_fill;

  logic                       req_kind;
  logic [BOARD_W-1:0]         req_board;
  logic [SLOT_W-1:0]          req_slot;
  logic                       req_activate;
  logic                       req_full;
  logic                       req_bad;

  logic                       out_valid;
  logic [STATUS_W-1:0]        out_status;
  logic [HANDLE_W-1:0]        out_granted;
  logic                       out_released;
  logic [COUNT_W-1:0]         out_live;

  logic [BOARDS-1:0]          has_room;
  logic [BOARDS-1:0]          is_newest;
  logic                       room_found;
  logic [BOARD_W-1:0]         room_board;
  logic                       idle_found;
  logic [BOARD_W-1:0]         idle_board;
  logic [BOARD_W-1:0]         hbrd;
  logic [SLOT_W-1:0]          hslot;
  logic                       hbad;
  logic [BOARD_W-1:0]         sel_board;
  logic                       accept;

  logic [SLOTS_PER_BOARD-1:0] map_rdata;
  logic [SLOTS_PER_BOARD-1:0] row;
  logic [SLOTS_PER_BOARD-1:0] map_wdata;
  logic                       map_we;
  logic                       free_found;
  logic [SLOT_W-1:0]          free_slot;
  logic                       ret_ok;
  logic                       out_free;
  logic                       fire;

  assign accept    = (state == S_IDLE) && req.valid;
  assign req.ready = (state == S_IDLE);
  assign out_free  = !out_valid || rsp.ready;
  assign fire      = (state == S_UPDATE) && out_free;

  assign hbrd  = BOARD_W'(req.handle / BOARD_STRIDE);
  assign hslot = SLOT_W'(req.handle % BOARD_STRIDE);

  always_comb begin
    for (int b = 0; b < BOARDS; b++) begin
      has_room[b] = board_active[b] && (int'(board_fill[b]) < SLOTS_PER_BOARD);
    end
    for (int b = 0; b < BOARDS; b++) begin
      is_newest[b] = has_room[b];
      for (int k = 0; k < BOARDS; k++) begin
        if (has_room[k] && (board_recency[k] < board_recency[b])) begin
          is_newest[b] = 1'b0;
        end
      end
    end
    room_found = 1'b0;
    room_board = '0;
    idle_found = 1'b0;
    idle_board = '0;
    for (int b = 0; b < BOARDS; b++) begin
      if (!room_found && is_newest[b]) begin
        room_found = 1'b1;
        room_board = BOARD_W'(b);
      end
      if (!idle_found && !board_active[b]) begin
        idle_found = 1'b1;
        idle_board = BOARD_W'(b);
      end
    end
    hbad = 1'b1;
    if ((int'(req.handle / BOARD_STRIDE) < BOARDS) && (int'(hslot) < SLOTS_PER_BOARD)) begin
      hbad = !board_active[hbrd];
    end
    if (req.kind == KIND_RETURN) begin
      sel_board = hbrd;
    end else if (room_found) begin
      sel_board = room_board;
    end else begin
      sel_board = idle_board;
    end
  end

  psa_ram #(
    .WIDTH (SLOTS_PER_BOARD),
    .DEPTH (BOARDS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (req_board),
    .wdata (map_wdata),
    .re    (accept),
    .raddr (sel_board),
    .rdata (map_rdata)
  );

  always_comb begin
    row        = req_activate ? '0 : map_rdata;
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = 0; s < SLOTS_PER_BOARD; s++) begin
      if (!free_found && !row[s]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(s);
      end
    end
    ret_ok = !req_bad && row[req_slot];
    map_we    = 1'b0;
    map_wdata = row;
    if (fire) begin
      if (req_kind == KIND_BORROW) begin
        map_we    = !req_full;
        map_wdata = row | (SLOTS_PER_BOARD'(1) << free_slot);
      end else begin
        map_we    = ret_ok;
        map_wdata = row & ~(SLOTS_PER_BOARD'(1) << req_slot);
      end
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.granted        = out_granted;
  assign rsp.board_released = out_released;
  assign rsp.live_count     = out_live;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pool_fill <= '0;
      for (int b = 0; b < BOARDS; b++) begin
        board_active[b]  <= 1'b0;
        board_fill[b]    <= '0;
        board_recency[b] <= '0;
      end
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_kind     <= req.kind;
            req_board    <= sel_board;
            req_slot     <= hslot;
            req_activate <= (req.kind == KIND_BORROW) && !room_found && idle_found;
            req_full     <= (req.kind == KIND_BORROW) && !room_found && !idle_found;
            req_bad      <= hbad;
            state        <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_status   <= ST_OK;
            out_granted  <= '0;
            out_released <= 1'b0;
            out_live     <= pool_fill;
            if (req_kind == KIND_BORROW) begin
              if (req_full) begin
                out_status <= ST_FULL;
              end else begin
                if (req_activate) begin
                  for (int k = 0; k < BOARDS; k++) begin
                    if (board_active[k]) begin
                      board_recency[k] <= board_recency[k] + BOARD_W'(1);
                    end
                  end
                  board_active[req_board]  <= 1'b1;
                  board_recency[req_board] <= '0;
                  board_fill[req_board]    <= FILL_W'(1);
                end else begin
                  board_fill[req_board] <= board_fill[req_board] + FILL_W'(1);
                end
                pool_fill   <= pool_fill + COUNT_W'(1);
                out_live    <= pool_fill + COUNT_W'(1);
                out_granted <= HANDLE_W'(int'(req_board) * BOARD_STRIDE + int'(free_slot));
              end
            end else begin
              if (!ret_ok) begin
                out_status <= ST_BAD;
              end else begin
                pool_fill <= pool_fill - COUNT_W'(1);
                out_live  <= pool_fill - COUNT_W'(1);
                if (board_fill[req_board] == FILL_W'(1)) begin
                  for (int k = 0; k < BOARDS; k++) begin
                    if (board_active[k] && (BOARD_W'(k) != req_board) &&
                        (board_recency[k] > board_recency[req_board])) begin
                      board_recency[k] <= board_recency[k] - BOARD_W'(1);
                    end
                  end
                  board_active[req_board]  <= 1'b0;
                  board_fill[req_board]    <= '0;
                  board_recency[req_board] <= '0;
                  out_released             <= 1'b1;
                end else begin
                  board_fill[req_board] <= board_fill[req_board] - FILL_W'(1);
                end
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/psa_checker.sv =====
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks of the slot allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module psa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [psa_pkg::STATUS_W-1:0]  rsp_status,
  input logic [psa_pkg::HANDLE_W-1:0]  rsp_granted,
  input logic                          rsp_released,
  input logic [psa_pkg::COUNT_W-1:0]   rsp_live
);

  import psa_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
    $stable(rsp_granted) && $stable(rsp_live))
    else $error("Response changed while stalled.");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_FULL) |-> (rsp_granted == '0) && !rsp_released &&
    (rsp_live == COUNT_W'(BOARDS * SLOTS_PER_BOARD)))
    else $error("Pool full response carries a grant, a release or a short count.");

  a_bad_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_BAD) |-> (rsp_granted == '0) && !rsp_released)
    else $error("Bad return response carries a grant or a release.");

  a_release_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_released |-> (rsp_status == ST_OK) && (rsp_granted == '0))
    else $error("Board release reported on a request that is not a good return.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == ST_OK) || (rsp_status == ST_FULL) ||
    (rsp_status == ST_BAD))
    else $error("Unknown response status.");

endmodule

bind pooled_slot_allocator psa_checker u_psa_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_status   (rsp.status),
  .rsp_granted  (rsp.granted),
  .rsp_released (rsp.board_released),
  .rsp_live     (rsp.live_count)
);
